[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg - shared definitions for the bounded deque
// Widths, command and status codes, and the control bundles that pass
// between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Store geometry.
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;

    // Command codes carried by the action field.
    typedef enum logic [2:0] {
        ACT_ADD_FRONT = 3'd0,
        ACT_ADD_BACK  = 3'd1,
        ACT_REM_FRONT = 3'd2,
        ACT_REM_BACK  = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_DUMP      = 3'd5,
        ACT_INS_AFTER = 3'd6,
        ACT_REM_AT    = 3'd7
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Kind of a store read: a shift towards the back, a shift towards the
    // front, or a dump read that produces a result.
    typedef enum logic [1:0] {
        RD_UP   = 2'd0,
        RD_DOWN = 2'd1,
        RD_DUMP = 2'd2
    } rd_kind_t;

    // Length update.
    typedef enum logic [1:0] {
        LEN_HOLD = 2'd0,
        LEN_INC  = 2'd1,
        LEN_DEC  = 2'd2,
        LEN_CLR  = 2'd3
    } len_op_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     capture;
        logic     setup;
        logic     rd_en;
        rd_kind_t rd_kind;
        logic     ptr_inc;
        logic     ptr_dec;
        logic     put_val;
        len_op_t  len_op;
        logic     emit;
        status_t  status;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        action_t action;
        logic    len_zero;
        logic    len_full;
        logic    pos_bad;
        logic    ptr_at_tgt;
        logic    ptr_below_len;
    } dp_stat_t;

endpackage

[rtl/bdq_datapath.sv]
// ----------------------------------------------------------------------------
// bdq_datapath - element store, pointers and result formatting
// Holds the slot memory, the length, the walking pointer and the gap index.
// Each shift read is written back one place up or down in the next cycle.
// ----------------------------------------------------------------------------
module bdq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bdq_pkg::dp_cmd_t                  cmd,
    output bdq_pkg::dp_stat_t                 stat,
    input  logic [2:0]                        action,
    input  logic [bdq_pkg::POS_W-1:0]         position,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [bdq_pkg::DATA_W-1:0] element,
    output logic                              last
);

    localparam int CMP_W =
        ((bdq_pkg::POS_W > bdq_pkg::PTR_W) ? bdq_pkg::POS_W : bdq_pkg::PTR_W) + 1;

    // Captured command.
    bdq_pkg::action_t                  action_reg;
    logic [bdq_pkg::POS_W-1:0]         position_reg;
    logic signed [bdq_pkg::DATA_W-1:0] value_reg;

    // Control registers.
    logic [bdq_pkg::PTR_W-1:0]  len_reg, len_next;
    logic [bdq_pkg::PTR_W-1:0]  ptr_reg, ptr_next;
    logic [bdq_pkg::PTR_W-1:0]  tgt_reg, tgt_next;
    logic                       rd_valid_reg;
    bdq_pkg::rd_kind_t          rd_kind_reg;
    logic [bdq_pkg::ADDR_W-1:0] rd_addr_reg;
    logic                       emit_reg;
    bdq_pkg::status_t           status_reg;

    // Store.
    logic signed [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::CAPACITY];
    logic signed [bdq_pkg::DATA_W-1:0] rdata_reg;

    logic [bdq_pkg::PTR_W-1:0]         ptr_m1;
    logic [bdq_pkg::PTR_W-1:0]         len_m1;
    logic [bdq_pkg::POS_W-1:0]         pos_m1;
    logic [bdq_pkg::ADDR_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [bdq_pkg::ADDR_W-1:0]        wr_addr;
    logic signed [bdq_pkg::DATA_W-1:0] wr_data;
    logic                              dump_valid;

    assign ptr_m1 = ptr_reg - 1'b1;
    assign len_m1 = len_reg - 1'b1;
    assign pos_m1 = position_reg - 1'b1;

    // Status back to the controller.
    always_comb
    begin
        stat.action        = action_reg;
        stat.len_zero      = (len_reg == '0);
        stat.len_full      = (len_reg == bdq_pkg::PTR_W'(bdq_pkg::CAPACITY));
        stat.pos_bad       = (position_reg == '0) ||
                             (CMP_W'(position_reg) > CMP_W'(len_reg));
        stat.ptr_at_tgt    = (ptr_reg == tgt_reg);
        stat.ptr_below_len = (ptr_reg < len_reg);
    end

    // Gap index and starting pointer for the captured command.
    always_comb
    begin
        tgt_next = tgt_reg;
        ptr_next = ptr_reg;
        if (cmd.setup)
        begin
            case (action_reg)
                bdq_pkg::ACT_ADD_BACK:  tgt_next = len_reg;
                bdq_pkg::ACT_INS_AFTER: tgt_next = bdq_pkg::PTR_W'(position_reg);
                bdq_pkg::ACT_REM_AT:    tgt_next = bdq_pkg::PTR_W'(pos_m1);
                default:                tgt_next = '0;
            endcase
            case (action_reg) inside
                bdq_pkg::ACT_ADD_FRONT,
                bdq_pkg::ACT_ADD_BACK,
                bdq_pkg::ACT_INS_AFTER: ptr_next = len_reg;
                bdq_pkg::ACT_DUMP:      ptr_next = '0;
                default:                ptr_next = tgt_next + 1'b1;
            endcase
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
    end

    // Length update.
    always_comb
    begin
        case (cmd.len_op)
            bdq_pkg::LEN_INC: len_next = len_reg + 1'b1;
            bdq_pkg::LEN_DEC: len_next = len_m1;
            bdq_pkg::LEN_CLR: len_next = '0;
            default:          len_next = len_reg;
        endcase
    end

    // Read address: an upward shift reads the element below the pointer.
    assign rd_addr = (cmd.rd_kind == bdq_pkg::RD_UP) ? ptr_m1[bdq_pkg::ADDR_W-1:0]
                                                     : ptr_reg[bdq_pkg::ADDR_W-1:0];

    // Single write port: the new value, or the write-back of a shift read.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = rdata_reg;
        if (cmd.put_val)
        begin
            wr_en   = 1'b1;
            wr_addr = tgt_reg[bdq_pkg::ADDR_W-1:0];
            wr_data = value_reg;
        end
        else if (rd_valid_reg && (rd_kind_reg == bdq_pkg::RD_UP))
        begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_reg + 1'b1;
        end
        else if (rd_valid_reg && (rd_kind_reg == bdq_pkg::RD_DOWN))
        begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_reg - 1'b1;
        end
    end

    // Slot memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Captured command fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= bdq_pkg::action_t'(action);
            position_reg <= position;
            value_reg    <= value;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr;
            rd_kind_reg <= cmd.rd_kind;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.status;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ptr_reg      <= '0;
            tgt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            ptr_reg      <= ptr_next;
            tgt_reg      <= tgt_next;
            rd_valid_reg <= cmd.rd_en;
            emit_reg     <= cmd.emit;
        end
    end

    // Result transaction: a status result or a dumped element.
    assign dump_valid = rd_valid_reg && (rd_kind_reg == bdq_pkg::RD_DUMP);
    assign done       = emit_reg || dump_valid;
    assign status     = emit_reg ? status_reg : bdq_pkg::ST_OK;
    assign element    = dump_valid ? rdata_reg : '0;
    assign last       = emit_reg ||
                        (dump_valid && (bdq_pkg::PTR_W'(rd_addr_reg) == len_m1));

endmodule

[rtl/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl - command sequencer for the bounded deque
// Decodes the captured command, checks it against the list state and steps
// the datapath through shifts, dumps and length updates.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output bdq_pkg::dp_cmd_t  cmd,
    input  bdq_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_OPEN,
        S_PUT,
        S_CLOSE,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_kind = bdq_pkg::RD_UP;
        cmd.len_op  = bdq_pkg::LEN_HOLD;
        cmd.status  = bdq_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.setup = 1'b1;
                unique case (stat.action) inside
                    bdq_pkg::ACT_ADD_FRONT,
                    bdq_pkg::ACT_ADD_BACK:
                    begin
                        if (stat.len_full)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_OPEN;
                        end
                    end
                    bdq_pkg::ACT_REM_FRONT:
                    begin
                        if (stat.len_zero)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CLOSE;
                        end
                    end
                    bdq_pkg::ACT_REM_BACK,
                    bdq_pkg::ACT_CLEAR:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                        if (stat.len_zero)
                        begin
                            cmd.status = bdq_pkg::ST_EMPTY;
                        end
                        else if (stat.action == bdq_pkg::ACT_CLEAR)
                        begin
                            cmd.len_op = bdq_pkg::LEN_CLR;
                        end
                        else
                        begin
                            cmd.len_op = bdq_pkg::LEN_DEC;
                        end
                    end
                    bdq_pkg::ACT_DUMP:
                    begin
                        if (stat.len_zero)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DUMP;
                        end
                    end
                    bdq_pkg::ACT_INS_AFTER:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_BADPOS;
                            state_next = S_IDLE;
                        end
                        else if (stat.len_full)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_OPEN;
                        end
                    end
                    default:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = bdq_pkg::ST_BADPOS;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CLOSE;
                        end
                    end
                endcase
            end
            // Walk down from the back, moving each element one place up.
            S_OPEN:
            begin
                if (!stat.ptr_at_tgt)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_kind = bdq_pkg::RD_UP;
                    cmd.ptr_dec = 1'b1;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            // Drop the new value into the gap.
            S_PUT:
            begin
                cmd.put_val = 1'b1;
                cmd.len_op  = bdq_pkg::LEN_INC;
                cmd.emit    = 1'b1;
                state_next  = S_IDLE;
            end
            // Walk up from the gap, moving each element one place down.
            S_CLOSE:
            begin
                if (stat.ptr_below_len)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_kind = bdq_pkg::RD_DOWN;
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    cmd.len_op = bdq_pkg::LEN_DEC;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Read the list front to back; each read becomes a result.
            S_DUMP:
            begin
                if (stat.ptr_below_len)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_kind = bdq_pkg::RD_DUMP;
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/bounded_deque_with_positional_ops_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_ops_core - bounded list of signed words
// Top level: joins the command sequencer to the store datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low; the
//   action, position and value ports are sampled at that edge.
//   Results leave on status, element and last, each valid for exactly one
//   cycle while done is high. The receiver cannot stall, so results are
//   never held back.
//   Every command but dump gives one status result with last set. Dump
//   gives one result per element, front to back, last on the final one,
//   or a single empty status for an empty list.
//   Remove back, clear and every refused command give their status
//   straight from the decide step. Adds and insert after move each element
//   from the gap index to the back one place up, and removes move each
//   element behind the gap one place down; the store has one read and one
//   write port and moves one element per cycle. A dump reads the list
//   front to back and shows one element per cycle. A new command is taken
//   once busy falls.
//   Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_ops_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        action,
    input  logic [bdq_pkg::POS_W-1:0]         position,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [bdq_pkg::DATA_W-1:0] element,
    output logic                              last
);

    bdq_pkg::dp_cmd_t  cmd;
    bdq_pkg::dp_stat_t stat;

    // Sequencer.
    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Store and result path.
    bdq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .action   (action),
        .position (position),
        .value    (value),
        .done     (done),
        .status   (status),
        .element  (element),
        .last     (last)
    );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the bounded deque core
// Sends deque commands through the start/busy handshake and predicts every
// status and dump transaction from a queue-based model of the list. Directed
// tests cover the empty list, both ends, positional edits and the full list.
// A long random mix follows, with idle bursts on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import bdq_pkg::*;

    // One expected result transaction.
    typedef struct {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } deque_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    // Model of the list contents, front at index 0.
    logic signed [DATA_W-1:0] list_model[$];
    // Results still owed by the core, oldest first.
    deque_result_t            pending_results[$];
    deque_result_t            oldest;
    int                       mismatch_count;
    bit                       idling_on;

    bounded_deque_with_positional_ops_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .position (position),
        .value    (value),
        .done     (done),
        .status   (status),
        .element  (element),
        .last     (last)
    );

    // Clock: 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Count a mismatch and report the first ten of them.
    task automatic note_mismatch(input string what, input deque_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch (%s): expected status=%0d element=%0d last=%0d,",
                     what, want.status, want.element, want.last);
            $display("    got status=%0d element=%0d last=%0d",
                     status, element, last);
        end
    endtask

    // Queue one expected result transaction.
    task automatic owe_result(input status_t st, input logic signed [31:0] elem,
                              input logic lst);
        deque_result_t r;
        r.status  = st;
        r.element = elem;
        r.last    = lst;
        pending_results.push_back(r);
    endtask

    // Apply one accepted command to the list model and queue its results.
    task automatic predict_command(input action_t act, input logic [POS_W-1:0] pos,
                                   input logic signed [31:0] val);
        int      len;
        int      p;
        status_t st;
        len = list_model.size();
        p   = int'(pos);
        st  = ST_OK;
        case (act)
            ACT_ADD_FRONT:
                if (len >= CAPACITY) st = ST_FULL;
                else list_model.push_front(val);
            ACT_ADD_BACK:
                if (len >= CAPACITY) st = ST_FULL;
                else list_model.push_back(val);
            ACT_REM_FRONT:
                if (len == 0) st = ST_EMPTY;
                else void'(list_model.pop_front());
            ACT_REM_BACK:
                if (len == 0) st = ST_EMPTY;
                else void'(list_model.pop_back());
            ACT_CLEAR:
                if (len == 0) st = ST_EMPTY;
                else list_model.delete();
            ACT_INS_AFTER:
                if (p < 1 || p > len) st = ST_BADPOS;
                else if (len >= CAPACITY) st = ST_FULL;
                else list_model.insert(p, val);
            ACT_REM_AT:
                if (p < 1 || p > len) st = ST_BADPOS;
                else list_model.delete(p - 1);
            default:
                st = ST_OK;
        endcase
        if (act == ACT_DUMP)
        begin
            if (len == 0)
                owe_result(ST_EMPTY, 32'sd0, 1'b1);
            else
                for (int i = 0; i < len; i++)
                    owe_result(ST_OK, list_model[i], (i == len - 1));
        end
        else
        begin
            owe_result(st, 32'sd0, 1'b1);
        end
    endtask

    // Offer one command and hold it until the core takes the transaction.
    task automatic send_command(input action_t act, input logic [POS_W-1:0] pos,
                                input logic signed [31:0] val);
        @(negedge clk);
        start    = 1'b1;
        action   = act;
        position = pos;
        value    = val;
        do
            @(posedge clk);
        while (busy);
        predict_command(act, pos, val);
    endtask

    // Random idle burst, sometimes placed where busy falls.
    task automatic command_gap();
        int n;
        if (!idling_on || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 3);
        @(negedge clk);
        start    = 1'b0;
        action   = 3'($urandom);
        position = POS_W'($urandom);
        value    = $urandom;
        if ($urandom_range(0, 1) == 1)
        begin
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic issue(input action_t act, input logic [POS_W-1:0] pos,
                         input logic signed [31:0] val);
        send_command(act, pos, val);
        command_gap();
    endtask

    // A position that is mostly valid for the current length.
    function automatic logic [POS_W-1:0] pick_position();
        int len;
        int r;
        len = list_model.size();
        r   = $urandom_range(0, 9);
        if (r < 8 && len > 0)
            return POS_W'($urandom_range(1, len));
        else if (r == 8)
            return ($urandom_range(0, 1) == 1) ? POS_W'(len + 1) : POS_W'(0);
        else
            return POS_W'($urandom);
    endfunction

    // A data word, sometimes one of the extremes.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Every removal, clear and dump on an empty list, and insert after at bad positions.
    task automatic test_empty_list();
        issue(ACT_REM_FRONT, 6'd0, 32'sd0);
        issue(ACT_REM_BACK, 6'd0, 32'sd0);
        issue(ACT_CLEAR, 6'd0, 32'sd0);
        issue(ACT_DUMP, 6'd0, 32'sd0);
        issue(ACT_REM_AT, 6'd1, 32'sd0);
        issue(ACT_INS_AFTER, 6'd0, 32'sd5);
        issue(ACT_INS_AFTER, 6'd1, 32'sd5);
    endtask

    // Adds and removals at both ends with extreme values.
    task automatic test_list_ends();
        issue(ACT_ADD_FRONT, 6'd0, 32'sh8000_0000);
        issue(ACT_ADD_BACK, 6'd63, 32'sh7fff_ffff);
        issue(ACT_ADD_FRONT, 6'd0, -32'sd1);
        issue(ACT_ADD_BACK, 6'd0, 32'sd0);
        issue(ACT_DUMP, 6'd0, 32'sd0);
        issue(ACT_REM_FRONT, 6'd0, 32'sd0);
        issue(ACT_REM_BACK, 6'd0, 32'sd0);
        issue(ACT_DUMP, 6'd0, 32'sd0);
    endtask

    // Insert after and remove at, good and bad positions.
    task automatic test_positional();
        issue(ACT_INS_AFTER, 6'd1, 32'sd11);
        issue(ACT_INS_AFTER, POS_W'(list_model.size()), 32'sd22);
        issue(ACT_INS_AFTER, POS_W'(list_model.size() + 1), 32'sd33);
        issue(ACT_INS_AFTER, 6'd0, 32'sd44);
        issue(ACT_INS_AFTER, 6'd63, 32'sd55);
        issue(ACT_REM_AT, 6'd2, 32'sd0);
        issue(ACT_REM_AT, POS_W'(list_model.size()), 32'sd0);
        issue(ACT_REM_AT, POS_W'(list_model.size() + 1), 32'sd0);
        issue(ACT_REM_AT, 6'd0, 32'sd0);
        issue(ACT_REM_AT, 6'd1, 32'sd0);
        issue(ACT_DUMP, 6'd0, 32'sd0);
    endtask

    // Fill to capacity, refuse further adds, then empty again.
    task automatic test_full_list();
        while (list_model.size() < CAPACITY)
            issue(ACT_ADD_BACK, 6'd0, pick_value());
        issue(ACT_ADD_FRONT, 6'd0, 32'sd1);
        issue(ACT_ADD_BACK, 6'd0, 32'sd2);
        issue(ACT_INS_AFTER, 6'd1, 32'sd3);
        issue(ACT_INS_AFTER, POS_W'(CAPACITY), 32'sd4);
        issue(ACT_INS_AFTER, POS_W'(CAPACITY + 1), 32'sd5);
        issue(ACT_INS_AFTER, 6'd0, 32'sd6);
        issue(ACT_DUMP, 6'd0, 32'sd0);
        issue(ACT_REM_AT, POS_W'(CAPACITY), 32'sd0);
        issue(ACT_ADD_FRONT, 6'd0, 32'sh7fff_ffff);
        issue(ACT_REM_AT, 6'd1, 32'sd0);
        issue(ACT_CLEAR, 6'd0, 32'sd0);
        issue(ACT_DUMP, 6'd0, 32'sd0);
    endtask

    // Random command mix in segments that grow, shrink or hold the list.
    task automatic test_random_mix(input int count);
        int      sent;
        int      seg_left;
        int      bias;
        int      r;
        action_t act;
        sent     = 0;
        seg_left = 0;
        bias     = 0;
        while (sent < count)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 40);
                bias     = $urandom_range(0, 2);
            end
            seg_left--;
            if (sent >= count - 50)
                idling_on = 1'b0;
            r = $urandom_range(0, 99);
            // Add-heavy when growing, removal-heavy when shrinking.
            if (r < 7)
                act = ACT_DUMP;
            else if (r < 10)
                act = ACT_CLEAR;
            else if (r < 10 + (bias == 0 ? 55 : (bias == 1 ? 15 : 35)))
                act = action_t'($urandom_range(0, 2) == 2 ? ACT_INS_AFTER
                                : $urandom_range(0, 1));
            else
                act = action_t'($urandom_range(0, 2) == 2 ? ACT_REM_AT
                                : $urandom_range(2, 3));
            issue(act, pick_position(), pick_value());
            sent++;
        end
    endtask

    // Result checker: every done cycle carries one result transaction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                oldest.status  = ST_OK;
                oldest.element = 32'sd0;
                oldest.last    = 1'b0;
                note_mismatch("unexpected result", oldest);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.status || element !== oldest.element
                    || last !== oldest.last)
                    note_mismatch("wrong field", oldest);
            end
        end
    end

    // Main sequence.
    initial
    begin
        int guard;
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = 3'd0;
        position       = '0;
        value          = '0;
        mismatch_count = 0;
        idling_on      = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_list_ends();
        test_positional();
        test_full_list();
        test_random_mix(380);

        @(negedge clk);
        start = 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (CAPACITY + 8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("** bounded_deque_with_positional_ops_core: PASSED **");
        else
            $display("** bounded_deque_with_positional_ops_core: FAILED **");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #500000;
        $display("timeout waiting for the core");
        $display("** bounded_deque_with_positional_ops_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/bdq_pkg.sv
rtl/bdq_datapath.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_positional_ops_core.sv
verif/testbench.sv
